/* rtl/rgbhsl_pkg.sv */
// Shared types and constants for the RGB to HSL converter.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none

package rgbhsl_pkg;

  localparam int COMP_W   = 8;   // one color component
  localparam int DIV_W    = 9;   // divisor: twice delta or twice the saturation denominator
  localparam int QUO_W    = 17;  // quotient bits, one per cell
  localparam int NUM_W    = 25;  // widest dividend (saturation)
  localparam int HUE_W    = 15;
  localparam int SAT_W    = 16;
  localparam int SUM_W    = 9;
  localparam int HUE_Q_W  = 12;  // hue term never exceeds 3840
  localparam int NUM_CELLS = QUO_W;

  localparam logic [HUE_W:0] HUE_FULL  = 16'd23040;  // 360 degrees * 64
  localparam logic [HUE_W:0] HUE_120   = 16'd7680;
  localparam logic [HUE_W:0] HUE_240   = 16'd15360;
  localparam logic [12:0]    HUE_SCALE = 13'd7680;   // 2 * 60 * 64
  localparam logic [16:0]    SAT_SCALE = 17'd131070; // 2 * 65535
  localparam logic [SUM_W-1:0] SUM_HALF = 9'd255;
  localparam logic [SUM_W-1:0] SUM_FULL = 9'd510;
  localparam logic [SAT_W-1:0] SAT_MAX  = 16'hFFFF;

  // Which component holds the max (ties go red, then green).
  typedef enum logic [1:0] {
    REGION_RED,
    REGION_GREEN,
    REGION_BLUE
  } region_t;

  // One division lane: partial remainder, divisor, and a word that starts as
  // the low dividend bits and fills with quotient bits from the right.
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] div;
    logic [QUO_W-1:0] low;
  } lane_t;

  // What one cell hands to the next.
  typedef struct packed {
    logic             valid;
    logic             gray;
    logic             neg;
    region_t          region;
    logic [SUM_W-1:0] sum;
    lane_t            hue;
    lane_t            sat;
  } cell_t;

  typedef struct packed {
    logic [SUM_W-1:0] lightness_sum;
    logic [SAT_W-1:0] saturation;
    logic [HUE_W-1:0] hue;
  } result_t;

endpackage

`default_nettype wire

/* rtl/rgb_to_hsl_converter.sv */
// RGB to HSL converter: front stage, a row of 17 division cells, back stage
// and an output skid register. Depends on rgbhsl_pkg and all rgbhsl_* modules.
//
// One pixel in per clock, one HSL result out per pixel, in order. A pixel is
// taken every cycle while the output side keeps up; m_tvalid rises once the
// pixel has passed the front stage (loaded at the accepting edge), the 17 cells,
// the back stage and the output register, in that order. The divisions (hue
// term and saturation) run as a chain of restoring-division cells, each
// settling one quotient bit of both lanes per cycle while not stalled, so
// throughput is one item per clock except in a stall. The pipeline advances
// as a whole and stalls only when the two-entry output buffer is full; s_tready
// comes from a register, so there is no combinational path from m_tready.
// Hue is degrees*64 rounded to nearest in 0..23039, saturation is S*65535
// rounded, lightness_sum is max+min. Gray pixels give hue 0, saturation 0.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsl_converter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // hue [14:0], saturation [30:15], lightness_sum [39:31]
);

  // whole pipeline moves while the skid slot is free
  logic                advance;
  logic                skid_valid;
  rgbhsl_pkg::result_t skid_data;
  rgbhsl_pkg::result_t out_data;
  logic                back_valid;
  rgbhsl_pkg::result_t back_data;
  logic                push;

  rgbhsl_pkg::cell_t chain [rgbhsl_pkg::NUM_CELLS+1];

  assign advance  = ~skid_valid;
  assign s_tready = ~skid_valid & ~rst;

  rgbhsl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (s_tvalid & s_tready),
    .red      (s_tdata[7:0]),
    .green    (s_tdata[15:8]),
    .blue     (s_tdata[23:16]),
    .q        (chain[0])
  );

  for (genvar i = 0; i < rgbhsl_pkg::NUM_CELLS; i++) begin : g_cell
    rgbhsl_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (advance),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  rgbhsl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .d         (chain[rgbhsl_pkg::NUM_CELLS]),
    .out_valid (back_valid),
    .out_data  (back_data)
  );

  // an item leaves the back stage only when the pipeline advances
  assign push = back_valid & advance;

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      out_data <= skid_valid ? skid_data : back_data;
    end
    if (!(m_tready || !m_tvalid) && push) begin
      skid_data <= back_data;
    end
  end

  assign m_tdata = {out_data.lightness_sum, out_data.saturation, out_data.hue};

`ifndef NO_ASSERTIONS
  // skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry valid without output valid");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled while output was free");

  // black pixel: all-zero outputs
  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[39:31] == '0) |-> (m_tdata[30:0] == '0))
    else $error("nonzero hue or saturation for black");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[14:0] < 15'd23040))
    else $error("hue out of range");
`endif

endmodule

`default_nettype wire

/* rtl/rgbhsl_front.sv */
// Front stage: max/min, hue sector, and the two rounded dividends.
// Depends on rgbhsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsl_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [rgbhsl_pkg::COMP_W-1:0] red,
  input  wire logic [rgbhsl_pkg::COMP_W-1:0] green,
  input  wire logic [rgbhsl_pkg::COMP_W-1:0] blue,
  output rgbhsl_pkg::cell_t                  q
);

  logic [rgbhsl_pkg::COMP_W-1:0] mx, mn, p_c, q_c, mag, delta, den;
  logic [rgbhsl_pkg::SUM_W-1:0]  sum;
  rgbhsl_pkg::region_t           region;
  logic                          neg;
  logic [rgbhsl_pkg::NUM_W-1:0]  hue_num, sat_num;
  rgbhsl_pkg::cell_t             d;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};

    if (mx == red) begin
      region = rgbhsl_pkg::REGION_RED;
      p_c = green;
      q_c = blue;
    end else if (mx == green) begin
      region = rgbhsl_pkg::REGION_GREEN;
      p_c = blue;
      q_c = red;
    end else begin
      region = rgbhsl_pkg::REGION_BLUE;
      p_c = red;
      q_c = green;
    end
    neg = (p_c < q_c);
    mag = neg ? (q_c - p_c) : (p_c - q_c);

    // den stays below 256 on both sides of the lightness midpoint
    if (sum <= rgbhsl_pkg::SUM_HALF) den = sum[rgbhsl_pkg::COMP_W-1:0];
    else den = 8'(rgbhsl_pkg::SUM_FULL - sum);

    // round to nearest: (2*k*x + d) / (2*d)
    hue_num = rgbhsl_pkg::NUM_W'(mag) * rgbhsl_pkg::NUM_W'(rgbhsl_pkg::HUE_SCALE)
            + rgbhsl_pkg::NUM_W'(delta);
    sat_num = rgbhsl_pkg::NUM_W'(delta) * rgbhsl_pkg::NUM_W'(rgbhsl_pkg::SAT_SCALE)
            + rgbhsl_pkg::NUM_W'(den);

    d.valid    = in_valid;
    d.gray     = (delta == '0);
    d.neg      = neg;
    d.region   = region;
    d.sum      = sum;
    d.hue.div  = {delta, 1'b0};
    d.hue.rem  = {1'b0, hue_num[rgbhsl_pkg::NUM_W-1:rgbhsl_pkg::QUO_W]};
    d.hue.low  = hue_num[rgbhsl_pkg::QUO_W-1:0];
    d.sat.div  = {den, 1'b0};
    d.sat.rem  = {1'b0, sat_num[rgbhsl_pkg::NUM_W-1:rgbhsl_pkg::QUO_W]};
    d.sat.low  = sat_num[rgbhsl_pkg::QUO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.gray   <= d.gray;
      q.neg    <= d.neg;
      q.region <= d.region;
      q.sum    <= d.sum;
      q.hue    <= d.hue;
      q.sat    <= d.sat;
    end
  end

endmodule

`default_nettype wire

/* rtl/rgbhsl_div_cell.sv */
// One restoring-division step for both lanes (hue and saturation).
// Depends on rgbhsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsl_div_cell (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire rgbhsl_pkg::cell_t d,
  output rgbhsl_pkg::cell_t q
);

  rgbhsl_pkg::lane_t hue_next, sat_next;

  function automatic rgbhsl_pkg::lane_t div_step(input rgbhsl_pkg::lane_t l);
    logic [rgbhsl_pkg::DIV_W:0] t;
    logic                        ge;
    rgbhsl_pkg::lane_t           r;
    t  = {l.rem, l.low[rgbhsl_pkg::QUO_W-1]};
    ge = (t >= {1'b0, l.div});
    r.div = l.div;
    // remainder stays below the divisor, so the difference fits
    r.rem = ge ? rgbhsl_pkg::DIV_W'(t - {1'b0, l.div}) : t[rgbhsl_pkg::DIV_W-1:0];
    r.low = {l.low[rgbhsl_pkg::QUO_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    hue_next = div_step(d.hue);
    sat_next = div_step(d.sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.gray   <= d.gray;
      q.neg    <= d.neg;
      q.region <= d.region;
      q.sum    <= d.sum;
      q.hue    <= hue_next;
      q.sat    <= sat_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rgbhsl_back.sv */
// Back stage: adds the sector base, wraps hue, clamps saturation.
// Depends on rgbhsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsl_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire rgbhsl_pkg::cell_t d,
  output logic            out_valid,
  output rgbhsl_pkg::result_t out_data
);

  logic [rgbhsl_pkg::HUE_W:0]   base, hue_raw, hue_wrap;
  logic [rgbhsl_pkg::HUE_Q_W-1:0] hq;
  logic [rgbhsl_pkg::QUO_W-1:0] sq;
  logic [rgbhsl_pkg::SAT_W-1:0] sat;
  rgbhsl_pkg::result_t          r;

  always_comb begin
    case (d.region)
      rgbhsl_pkg::REGION_RED:   base = '0;
      rgbhsl_pkg::REGION_GREEN: base = rgbhsl_pkg::HUE_120;
      rgbhsl_pkg::REGION_BLUE:  base = rgbhsl_pkg::HUE_240;
      default:                  base = '0;
    endcase
    hq = d.hue.low[rgbhsl_pkg::HUE_Q_W-1:0];
    sq = d.sat.low;

    if (d.neg) hue_raw = base + rgbhsl_pkg::HUE_FULL - (rgbhsl_pkg::HUE_W+1)'(hq);
    else hue_raw = base + (rgbhsl_pkg::HUE_W+1)'(hq);
    hue_wrap = (hue_raw >= rgbhsl_pkg::HUE_FULL) ? hue_raw - rgbhsl_pkg::HUE_FULL : hue_raw;

    sat = sq[rgbhsl_pkg::QUO_W-1] ? rgbhsl_pkg::SAT_MAX : sq[rgbhsl_pkg::SAT_W-1:0];

    r.lightness_sum = d.sum;
    r.hue           = d.gray ? '0 : hue_wrap[rgbhsl_pkg::HUE_W-1:0];
    r.saturation    = d.gray ? '0 : sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= r;
    end
  end

endmodule

`default_nettype wire

/* tb/rgb_to_hsl_converter_tb.sv */
// Self-checking bench for rgb_to_hsl_converter: directed pixel table, then random pixels
// under four idle/stall mixes, each result checked field by field against a typed-in
// answer or a local model. Depends on rgbhsl_pkg (result_t) and the RTL under rtl/.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_tb;

  // Hue units are 1/64 degree.
  localparam int unsigned DEG_360 = 23040;
  localparam int unsigned DEG_120 = 7680;
  localparam int unsigned DEG_240 = 15360;
  localparam int unsigned HUE_SPAN = 3840;   // 60 degrees
  localparam int unsigned SAT_ONE  = 65535;

  localparam int RANDOM_PER_PHASE = 458;
  localparam int HOLD_CYCLES      = 400;     // long receiver hold-off
  localparam int DRAIN_CYCLES     = 40;      // pipeline is 20 deep
  localparam int QUIET_LIMIT      = 3000;    // cycles with no item moving on either side
  localparam int PRINT_CAP        = 50;

  // Expected result plus the pixel that caused it, for the error line.
  typedef struct {
    logic [23:0]         px;
    rgbhsl_pkg::result_t want;
  } hsl_expect_t;

  // One row of the directed table; known rows carry a typed-in answer.
  typedef struct {
    logic [7:0]          r;
    logic [7:0]          g;
    logic [7:0]          b;
    bit                  known;
    rgbhsl_pkg::result_t want;
  } pixel_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;      // red [7:0], green [15:8], blue [23:16]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // hue [14:0], saturation [30:15], lightness_sum [39:31]

  hsl_expect_t pending_hsl[$];
  pixel_row_t  pixel_table[$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          pressure_go = 1'b0;

  rgb_to_hsl_converter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact integer HSL of one pixel: hue term and saturation are rounded
  // to nearest, half up; gray gives hue 0 and saturation 0.
  function automatic rgbhsl_pkg::result_t hsl_of_pixel(input logic [7:0] r,
                                                       input logic [7:0] g,
                                                       input logic [7:0] b);
    int unsigned         hi, lo, span, total, base, mag, term, hue_v, den, sat_v;
    bit                  neg;
    rgbhsl_pkg::result_t res;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    span  = hi - lo;
    total = hi + lo;
    hue_v = 0;
    sat_v = 0;
    if (span != 0) begin
      // Max tie: red beats green, green beats blue.
      if (hi == r) begin
        base = 0;
        neg  = g < b;
        mag  = neg ? b - g : g - b;
      end else if (hi == g) begin
        base = DEG_120;
        neg  = b < r;
        mag  = neg ? r - b : b - r;
      end else begin
        base = DEG_240;
        neg  = r < g;
        mag  = neg ? g - r : r - g;
      end
      // Round on the magnitude, then apply the sign.
      term  = (2 * HUE_SPAN * mag + span) / (2 * span);
      hue_v = neg ? base + DEG_360 - term : base + term;
      if (hue_v >= DEG_360) hue_v -= DEG_360;
      den   = (total <= 255) ? total : 510 - total;
      sat_v = (2 * SAT_ONE * span + den) / (2 * den);
      if (sat_v > SAT_ONE) sat_v = SAT_ONE;
    end
    res.hue           = hue_v[14:0];
    res.saturation    = sat_v[15:0];
    res.lightness_sum = total[8:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] px,
                                 input int unsigned want, input int unsigned got);
    if (fail_count < PRINT_CAP)
      $display("[%0t] ERROR %s: pixel r=%0d g=%0d b=%0d expected %0d got %0d",
               $time, what, px[7:0], px[15:8], px[23:16], want, got);
    fail_count++;
  endtask

  task automatic add_row(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input bit known, input int unsigned hue, input int unsigned sat,
                         input int unsigned sum);
    pixel_row_t row;
    row.r = r;
    row.g = g;
    row.b = b;
    row.known = known;
    row.want.hue = hue[14:0];
    row.want.saturation = sat[15:0];
    row.want.lightness_sum = sum[8:0];
    pixel_table.push_back(row);
  endtask

  // Offer one pixel; the expectation is queued at the edge that accepts it.
  // s_tvalid stays high between back-to-back items, lowered only for idle cycles.
  task automatic send_pixel(input logic [23:0] px, input rgbhsl_pkg::result_t want);
    hsl_expect_t e;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    e.px   = px;
    e.want = want;
    pending_hsl.push_back(e);
  endtask

  // Random pixel, biased toward the corners of the conversion.
  function automatic logic [23:0] random_pixel();
    logic [7:0] r, g, b, v;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(9))
      6: begin                                  // gray
        g = r;
        b = r;
      end
      7: begin                                  // two components tie for the max
        v = 8'($urandom_range(255, 1));
        case ($urandom_range(2))
          0: begin r = v; g = v; b = 8'($urandom_range(v)); end
          1: begin g = v; b = v; r = 8'($urandom_range(v)); end
          default: begin r = v; b = v; g = 8'($urandom_range(v)); end
        endcase
      end
      8: begin                                  // components at the range ends
        r = ($urandom_range(1) != 0) ? 8'($urandom_range(255, 253)) : 8'($urandom_range(2));
        g = ($urandom_range(1) != 0) ? 8'($urandom_range(255, 253)) : 8'($urandom_range(2));
        b = ($urandom_range(1) != 0) ? 8'($urandom_range(255, 253)) : 8'($urandom_range(2));
      end
      9: begin                                  // nearly gray: tiny delta
        g = 8'(int'(r) + $urandom_range(3)) ;
        b = ($urandom_range(1) != 0) ? r : g;
      end
      default: ;                                // uniform
    endcase
    return {b, g, r};
  endfunction

  // Receiver: checks every accepted result against the oldest expectation,
  // then picks m_tready for the next edge. A pressure request holds m_tready
  // low for a long stretch so the pipeline fills and s_tready drops.
  initial begin : hsl_sink
    int                  hold_left;
    rgbhsl_pkg::result_t got;
    hsl_expect_t         e;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = rgbhsl_pkg::result_t'(m_tdata);
        if (pending_hsl.size() == 0) begin
          report_mismatch("result with nothing pending, hue", '0, 0, got.hue);
        end else begin
          e = pending_hsl.pop_front();
          if (got.hue !== e.want.hue)
            report_mismatch("hue", e.px, e.want.hue, got.hue);
          if (got.saturation !== e.want.saturation)
            report_mismatch("saturation", e.px, e.want.saturation, got.saturation);
          if (got.lightness_sum !== e.want.lightness_sum)
            report_mismatch("lightness_sum", e.px, e.want.lightness_sum, got.lightness_sum);
        end
      end
      if (pressure_go) begin
        hold_left   = HOLD_CYCLES;
        pressure_go = 1'b0;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends a run in which no item moves for too long.
  initial begin : stall_watch
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("rgb_to_hsl_converter: mismatch");
    $finish;
  end

  initial begin : pixel_source
    rgbhsl_pkg::result_t want;
    // Black, white, primaries, mid gray and near-black gray have typed-in answers.
    add_row(8'd0,   8'd0,   8'd0,   1'b1, 0,     0,     0);
    add_row(8'd255, 8'd255, 8'd255, 1'b1, 0,     0,     510);
    add_row(8'd255, 8'd0,   8'd0,   1'b1, 0,     65535, 255);
    add_row(8'd0,   8'd255, 8'd0,   1'b1, 7680,  65535, 255);
    add_row(8'd0,   8'd0,   8'd255, 1'b1, 15360, 65535, 255);
    add_row(8'd128, 8'd128, 8'd128, 1'b1, 0,     0,     256);
    add_row(8'd1,   8'd1,   8'd1,   1'b1, 0,     0,     2);
    // Red hue below zero wraps up to between 300 and 360 degrees.
    add_row(8'd255, 8'd0,   8'd1,   1'b0, 0, 0, 0);
    add_row(8'd200, 8'd10,  8'd199, 1'b0, 0, 0, 0);
    // Ties for the max: red over green, green over blue, red over blue.
    add_row(8'd200, 8'd200, 8'd50,  1'b0, 0, 0, 0);
    add_row(8'd10,  8'd200, 8'd200, 1'b0, 0, 0, 0);
    add_row(8'd255, 8'd0,   8'd255, 1'b0, 0, 0, 0);
    add_row(8'd255, 8'd255, 8'd0,   1'b0, 0, 0, 0);
    add_row(8'd0,   8'd255, 8'd255, 1'b0, 0, 0, 0);
    // Green and blue regions on both sides of their base.
    add_row(8'd200, 8'd255, 8'd0,   1'b0, 0, 0, 0);
    add_row(8'd0,   8'd255, 8'd200, 1'b0, 0, 0, 0);
    add_row(8'd100, 8'd0,   8'd255, 1'b0, 0, 0, 0);
    add_row(8'd0,   8'd100, 8'd255, 1'b0, 0, 0, 0);
    // Saturation: exact half, both denominators, tiny delta near the top and the bottom.
    add_row(8'd150, 8'd50,  8'd50,  1'b0, 0, 0, 0);
    add_row(8'd255, 8'd128, 8'd128, 1'b0, 0, 0, 0);
    add_row(8'd255, 8'd200, 8'd200, 1'b0, 0, 0, 0);
    add_row(8'd255, 8'd254, 8'd254, 1'b0, 0, 0, 0);
    add_row(8'd1,   8'd0,   8'd0,   1'b0, 0, 0, 0);
    add_row(8'd170, 8'd85,  8'd127, 1'b0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rows, no idling.
    foreach (pixel_table[i]) begin
      want = pixel_table[i].known
             ? pixel_table[i].want
             : hsl_of_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b);
      send_pixel({pixel_table[i].b, pixel_table[i].g, pixel_table[i].r}, want);
    end

    // Random phases: none idle (with a long receiver hold-off at its start),
    // sender idle 60%, receiver stalling 60%, both at 16%.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  pressure_go = 1'b1; end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        logic [23:0] px;
        px = random_pixel();
        send_pixel(px, hsl_of_pixel(px[7:0], px[15:8], px[23:16]));
      end
    end
    s_tvalid <= 1'b0;

    while (pending_hsl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("rgb_to_hsl_converter: match");
    else
      $display("rgb_to_hsl_converter: mismatch");
    $finish;
  end

endmodule
